// ===== rtl/core/ptl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared types and constants for the poly-tail trim length block.
// ----------------------------------------------------------------------------
package ptl_pkg;

  localparam int CFG_LEN_W  = 16;
  localparam int CHAR_W     = 8;
  localparam int OUT_LEN_W  = 16;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 40;

  localparam logic [CFG_LEN_W-1:0] MIN_KEEP_RST      = 16'd4;
  localparam logic [CFG_LEN_W-1:0] MIN_TRIM_RST      = 16'd16;
  localparam logic [CHAR_W-1:0]    FIRST_TARGET_RST  = 8'd65;  // 'A'
  localparam logic [CHAR_W-1:0]    SECOND_TARGET_RST = 8'd84;  // 'T'

  typedef enum logic [1:0] {
    REG_MIN_KEEP      = 2'd0,
    REG_MIN_TRIM      = 2'd1,
    REG_FIRST_TARGET  = 2'd2,
    REG_SECOND_TARGET = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_LEN_W-1:0] min_keep;
    logic [CFG_LEN_W-1:0] min_trim;
    logic [CHAR_W-1:0]    first_target;
    logic [CHAR_W-1:0]    second_target;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/ptl_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptl_cfg
// APB register file: trim thresholds and the two target characters.
// ----------------------------------------------------------------------------
module ptl_cfg
  import ptl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MIN_KEEP:      cfg_d.min_keep      = pwdata[CFG_LEN_W-1:0];
        REG_MIN_TRIM:      cfg_d.min_trim      = pwdata[CFG_LEN_W-1:0];
        REG_FIRST_TARGET:  cfg_d.first_target  = pwdata[CHAR_W-1:0];
        REG_SECOND_TARGET: cfg_d.second_target = pwdata[CHAR_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_KEEP:      prdata = {{(PDATA_W-CFG_LEN_W){1'b0}}, cfg_q.min_keep};
      REG_MIN_TRIM:      prdata = {{(PDATA_W-CFG_LEN_W){1'b0}}, cfg_q.min_trim};
      REG_FIRST_TARGET:  prdata = {{(PDATA_W-CHAR_W){1'b0}}, cfg_q.first_target};
      REG_SECOND_TARGET: prdata = {{(PDATA_W-CHAR_W){1'b0}}, cfg_q.second_target};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_keep      <= MIN_KEEP_RST;
      cfg_q.min_trim      <= MIN_TRIM_RST;
      cfg_q.first_target  <= FIRST_TARGET_RST;
      cfg_q.second_target <= SECOND_TARGET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/core/ptl_count.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptl_count
// Per-read run tracking; registers a snapshot of the counts on the last base.
// ----------------------------------------------------------------------------
module ptl_count
  import ptl_pkg::*;
#(
  parameter int LEN_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                adv_i,
  input  logic                accept_i,
  input  logic [CHAR_W-1:0]   base_i,
  input  logic                last_i,
  output logic                snap_valid_o,
  output logic [LEN_BITS-1:0] snap_size_o,
  output logic [LEN_BITS-1:0] snap_first_o,
  output logic [LEN_BITS-1:0] snap_second_o,
  output logic [LEN_BITS-1:0] snap_srbf_o,
  output logic [LEN_BITS-1:0] pos_o
);

  localparam logic [LEN_BITS-1:0] LenMax = '1;

  logic [LEN_BITS-1:0] pos_q, pos_d, first_q, first_d, second_q, second_d;
  logic [LEN_BITS-1:0] srbf_q, srbf_d;
  logic [LEN_BITS-1:0] pos_upd, first_upd, second_upd, srbf_upd;
  logic                snap_valid_q;
  logic [LEN_BITS-1:0] snap_size_q, snap_first_q, snap_second_q, snap_srbf_q;
  logic                is_first, is_second;

  assign is_first  = (base_i == cfg_i.first_target);
  assign is_second = (base_i == cfg_i.second_target);

  always_comb begin
    pos_upd = (pos_q == LenMax) ? pos_q : pos_q + 1'b1;
    if (is_first) begin
      // entering a new first-target run: remember the second-target run before it
      srbf_upd  = (first_q == '0) ? second_q : srbf_q;
      first_upd = (first_q == LenMax) ? first_q : first_q + 1'b1;
    end else begin
      srbf_upd  = '0;
      first_upd = '0;
    end
    if (is_second) begin
      second_upd = (second_q == LenMax) ? second_q : second_q + 1'b1;
    end else begin
      second_upd = '0;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    first_d  = first_q;
    second_d = second_q;
    srbf_d   = srbf_q;
    if (accept_i) begin
      if (last_i) begin
        pos_d    = '0;
        first_d  = '0;
        second_d = '0;
        srbf_d   = '0;
      end else begin
        pos_d    = pos_upd;
        first_d  = first_upd;
        second_d = second_upd;
        srbf_d   = srbf_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      first_q      <= '0;
      second_q     <= '0;
      srbf_q       <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      first_q  <= first_d;
      second_q <= second_d;
      srbf_q   <= srbf_d;
      if (adv_i) begin
        snap_valid_q <= accept_i & last_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      snap_size_q   <= pos_upd;
      snap_first_q  <= first_upd;
      snap_second_q <= second_upd;
      snap_srbf_q   <= srbf_upd;
    end
  end

  assign snap_valid_o  = snap_valid_q;
  assign snap_size_o   = snap_size_q;
  assign snap_first_o  = snap_first_q;
  assign snap_second_o = snap_second_q;
  assign snap_srbf_o   = snap_srbf_q;
  assign pos_o         = pos_q;

endmodule
`default_nettype wire

// ===== rtl/core/ptl_trim.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptl_trim
// Two registered trim passes: first-target cut, then second-target cut.
// ----------------------------------------------------------------------------
module ptl_trim
  import ptl_pkg::*;
#(
  parameter int LEN_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [LEN_BITS-1:0]  size_i,
  input  logic [LEN_BITS-1:0]  first_i,
  input  logic [LEN_BITS-1:0]  second_i,
  input  logic [LEN_BITS-1:0]  srbf_i,
  output logic                 valid_o,
  output logic [OUT_LEN_W-1:0] read_length_o,
  output logic [OUT_LEN_W-1:0] kept_length_o,
  output logic                 first_cut_o,
  output logic                 second_cut_o
);

  localparam int CW = (LEN_BITS > CFG_LEN_W) ? LEN_BITS : CFG_LEN_W;

  logic [CW-1:0] keep_x, trim_x;
  logic [CW-1:0] size_x, first_x, second_x, srbf_x;
  logic [CW-1:0] lim1, c1, len1, run2;
  logic          cut1;

  logic          p1_valid_q;
  logic [CW-1:0] p1_size_q, p1_len1_q, p1_run2_q;
  logic          p1_cut1_q;

  logic [CW-1:0] lim2, c2, kept;
  logic          cut2;

  logic                 out_valid_q;
  logic [OUT_LEN_W-1:0] out_read_q, out_kept_q;
  logic                 out_cut1_q, out_cut2_q;

  assign keep_x   = CW'(cfg_i.min_keep);
  assign trim_x   = CW'(cfg_i.min_trim);
  assign size_x   = CW'(size_i);
  assign first_x  = CW'(first_i);
  assign second_x = CW'(second_i);
  assign srbf_x   = CW'(srbf_i);

  // first pass
  always_comb begin
    lim1 = (size_x > keep_x) ? size_x - keep_x : '0;
    c1   = (first_x < lim1) ? first_x : lim1;
    cut1 = (c1 > trim_x);
    len1 = cut1 ? size_x - c1 : size_x;
    // a clamped cut leaves a rest still ending in first target: no second run
    if (cut1) begin
      run2 = (c1 == first_x) ? srbf_x : '0;
    end else begin
      run2 = second_x;
    end
  end

  // second pass
  always_comb begin
    lim2 = (p1_len1_q > keep_x) ? p1_len1_q - keep_x : '0;
    c2   = (p1_run2_q < lim2) ? p1_run2_q : lim2;
    cut2 = (c2 > trim_x);
    kept = cut2 ? p1_len1_q - c2 : p1_len1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      p1_valid_q  <= valid_i;
      out_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p1_size_q  <= size_x;
      p1_len1_q  <= len1;
      p1_run2_q  <= run2;
      p1_cut1_q  <= cut1;
      out_read_q <= p1_size_q[OUT_LEN_W-1:0];
      out_kept_q <= kept[OUT_LEN_W-1:0];
      out_cut1_q <= p1_cut1_q;
      out_cut2_q <= cut2;
    end
  end

  assign valid_o       = out_valid_q;
  assign read_length_o = out_read_q;
  assign kept_length_o = out_kept_q;
  assign first_cut_o   = out_cut1_q;
  assign second_cut_o  = out_cut2_q;

endmodule
`default_nettype wire

// ===== rtl/core/poly_tail_trim_length.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// poly_tail_trim_length
// Streaming poly-tail trimmer: read length and kept length per read.
// ----------------------------------------------------------------------------
// One read character is taken per beat, one beat per clock while the output
// side is ready. The beat flagged tlast produces one result beat, which
// passes the count snapshot at the accepting edge, then the first-pass
// register, then the second-pass output register; other beats produce
// nothing. All pipeline stages advance together whenever
// the output register is empty or being taken, so a stalled result holds the
// whole pipe and s_axis_tready drops. Counts saturate at 2**LEN_BITS-1; the
// reported lengths are the low 16 bits. Registers: 0x0 min_keep, 0x4
// min_trim, 0x8 first_target, 0xC second_target.
module poly_tail_trim_length
  import ptl_pkg::*;
#(
  parameter int LEN_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  // read characters
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] base
  input  logic                 s_axis_tlast,
  // results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] read_length, [31:16] kept_length, [32] first_cut, [33] second_cut
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  cfg_t                 cfg;
  logic                 adv, s_accept;
  logic                 snap_valid;
  logic [LEN_BITS-1:0]  snap_size, snap_first, snap_second, snap_srbf, pos;
  logic [OUT_LEN_W-1:0] read_length, kept_length;
  logic                 first_cut, second_cut;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign s_accept      = s_axis_tvalid & s_axis_tready;

  ptl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ptl_count #(
    .LEN_BITS (LEN_BITS)
  ) u_count (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .adv_i         (adv),
    .accept_i      (s_accept),
    .base_i        (s_axis_tdata[CHAR_W-1:0]),
    .last_i        (s_axis_tlast),
    .snap_valid_o  (snap_valid),
    .snap_size_o   (snap_size),
    .snap_first_o  (snap_first),
    .snap_second_o (snap_second),
    .snap_srbf_o   (snap_srbf),
    .pos_o         (pos)
  );

  ptl_trim #(
    .LEN_BITS (LEN_BITS)
  ) u_trim (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .adv_i         (adv),
    .valid_i       (snap_valid),
    .size_i        (snap_size),
    .first_i       (snap_first),
    .second_i      (snap_second),
    .srbf_i        (snap_srbf),
    .valid_o       (m_axis_tvalid),
    .read_length_o (read_length),
    .kept_length_o (kept_length),
    .first_cut_o   (first_cut),
    .second_cut_o  (second_cut)
  );

  assign m_axis_tdata = {{(M_TDATA_W - 2*OUT_LEN_W - 2){1'b0}},
                         second_cut, first_cut, kept_length, read_length};

  // counts restart after the last beat of a read
  a_count_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tlast) |=> (pos == '0))
    else $error("position count not cleared after last beat");

  // without a cut the whole read is kept
  a_no_cut_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !first_cut && !second_cut) |-> (kept_length == read_length))
    else $error("kept length differs from read length without a cut");

  // a snapshot only appears from a last beat taken in the previous cycle
  a_snap_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(snap_valid) |-> $past(s_accept && s_axis_tlast))
    else $error("result snapshot without a last beat");

endmodule
`default_nettype wire
